/* sv/rae_pkg.sv */
// ----------------------------------------------------------------------------
// rae_pkg: register ALU instruction executor shared definitions
// Opcodes, ALU operation codes, control structs and field widths.
// ----------------------------------------------------------------------------
package rae_pkg;

    localparam int OPC_W          = 4;
    localparam int IDX_W          = 5;
    localparam int IMM_W          = 32;
    localparam int VAL_W          = 32;
    localparam int S_TDATA_W      = 56;
    localparam int M_TDATA_W      = 32;
    localparam int DEF_NUM_REGS   = 26;
    localparam int DEF_DATA_WIDTH = 32;

    typedef enum logic [OPC_W-1:0] {
        OP_LOAD   = 4'd0,
        OP_OUTPUT = 4'd1,
        OP_MOVE   = 4'd2,
        OP_EXCH   = 4'd3,
        OP_ADD    = 4'd4,
        OP_SUB    = 4'd5,
        OP_MUL    = 4'd6,
        OP_DIV    = 4'd7,
        OP_MOD    = 4'd8,
        OP_AND    = 4'd9,
        OP_OR     = 4'd10,
        OP_XOR    = 4'd11
    } opcode_t;

    typedef enum logic [2:0] {
        ALU_ADD,
        ALU_SUB,
        ALU_MUL,
        ALU_DIV,
        ALU_MOD,
        ALU_AND,
        ALU_OR,
        ALU_XOR
    } alu_op_t;

    typedef struct packed {
        logic    start;
        alu_op_t op;
    } alu_req_t;

    typedef struct packed {
        logic done;
        logic div_zero;
    } alu_rsp_t;

    typedef struct packed {
        logic             en;
        logic [IDX_W-1:0] idx0;
        logic [IDX_W-1:0] idx1;
    } rf_rd_req_t;

    typedef struct packed {
        logic             en;
        logic [IDX_W-1:0] idx;
    } rf_wr_req_t;

    function automatic alu_op_t alu_op_of(opcode_t opc);
        alu_op_t op;
        case (opc)
            OP_ADD:  op = ALU_ADD;
            OP_SUB:  op = ALU_SUB;
            OP_MUL:  op = ALU_MUL;
            OP_DIV:  op = ALU_DIV;
            OP_MOD:  op = ALU_MOD;
            OP_AND:  op = ALU_AND;
            OP_OR:   op = ALU_OR;
            default: op = ALU_XOR;
        endcase
        return op;
    endfunction

endpackage

/* sv/rae_regfile.sv */
// ----------------------------------------------------------------------------
// rae_regfile: register file
// Two registered read ports, one write port; per-entry valid bits give the
// all-zero reset state. Indices at or above NUM_REGS read zero, writes dropped.
// ----------------------------------------------------------------------------
module rae_regfile #(
    parameter int NUM_REGS   = rae_pkg::DEF_NUM_REGS,
    parameter int DATA_WIDTH = rae_pkg::DEF_DATA_WIDTH
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  rae_pkg::rf_rd_req_t    rd,
    output logic [DATA_WIDTH-1:0]  rd_data0,
    output logic [DATA_WIDTH-1:0]  rd_data1,
    input  rae_pkg::rf_wr_req_t    wr,
    input  logic [DATA_WIDTH-1:0]  wr_data
);
    import rae_pkg::*;

    localparam int AW = $clog2(NUM_REGS);

    logic [DATA_WIDTH-1:0] mem [NUM_REGS];
    logic [NUM_REGS-1:0]   valid_reg;
    logic [DATA_WIDTH-1:0] raw0_reg;
    logic [DATA_WIDTH-1:0] raw1_reg;
    logic                  ok0_reg;
    logic                  ok1_reg;
    logic                  wr_ok;

    function automatic logic in_range(logic [IDX_W-1:0] idx);
        return {1'b0, idx} < (IDX_W+1)'(NUM_REGS);
    endfunction

    assign wr_ok = wr.en && in_range(wr.idx);

    always_ff @(posedge clk)
    begin
        if (wr_ok)
        begin
            mem[wr.idx[AW-1:0]] <= wr_data;
        end
        if (rd.en)
        begin
            raw0_reg <= mem[rd.idx0[AW-1:0]];
            raw1_reg <= mem[rd.idx1[AW-1:0]];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            ok0_reg   <= 1'b0;
            ok1_reg   <= 1'b0;
        end
        else
        begin
            if (wr_ok)
            begin
                valid_reg[wr.idx[AW-1:0]] <= 1'b1;
            end
            if (rd.en)
            begin
                ok0_reg <= in_range(rd.idx0) && valid_reg[rd.idx0[AW-1:0]];
                ok1_reg <= in_range(rd.idx1) && valid_reg[rd.idx1[AW-1:0]];
            end
        end
    end

    assign rd_data0 = ok0_reg ? raw0_reg : '0;
    assign rd_data1 = ok1_reg ? raw1_reg : '0;

endmodule

/* sv/rae_alu.sv */
// ----------------------------------------------------------------------------
// rae_alu: iterative arithmetic unit
// One shared adder/subtractor serves add, sub, shift-add multiply, magnitude
// negation, restoring division and sign correction.
// ----------------------------------------------------------------------------
module rae_alu #(
    parameter int DATA_WIDTH = rae_pkg::DEF_DATA_WIDTH
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  rae_pkg::alu_req_t      req,
    input  logic [DATA_WIDTH-1:0]  x,
    input  logic [DATA_WIDTH-1:0]  y,
    output logic [DATA_WIDTH-1:0]  result,
    output rae_pkg::alu_rsp_t      rsp
);
    import rae_pkg::*;

    localparam int W  = DATA_WIDTH;
    localparam int CW = $clog2(DATA_WIDTH);

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_MAGX,
        S_MAGY,
        S_ITER,
        S_FIX,
        S_DONE
    } state_t;

    state_t        state_reg, state_next;
    alu_op_t       op_reg, op_next;
    logic [W-1:0]  opa_reg, opa_next;
    logic [W-1:0]  opb_reg, opb_next;
    logic [W-1:0]  acc_reg, acc_next;
    logic [W-1:0]  res_reg, res_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          neg_reg, neg_next;
    logic          zero_reg, zero_next;

    logic [W-1:0]  add_a;
    logic [W-1:0]  add_b;
    logic          add_sub;
    logic [W:0]    sum;
    logic [W-1:0]  div_sh;

    assign div_sh = {acc_reg[W-2:0], opa_reg[W-1]};
    assign sum    = {1'b0, add_a} + ({1'b0, add_b} ^ {(W+1){add_sub}}) + (W+1)'(add_sub);

    always_comb
    begin
        add_a   = opa_reg;
        add_b   = opb_reg;
        add_sub = 1'b0;
        case (state_reg)
            S_EXEC:
            begin
                add_sub = (op_reg == ALU_SUB);
            end
            S_MAGX:
            begin
                add_a   = '0;
                add_b   = opa_reg;
                add_sub = 1'b1;
            end
            S_MAGY:
            begin
                add_a   = '0;
                add_b   = opb_reg;
                add_sub = 1'b1;
            end
            S_ITER:
            begin
                if (op_reg == ALU_MUL)
                begin
                    add_a = acc_reg;
                    add_b = opa_reg;
                end
                else
                begin
                    add_a   = div_sh;
                    add_b   = opb_reg;
                    add_sub = 1'b1;
                end
            end
            S_FIX:
            begin
                add_a   = '0;
                add_b   = (op_reg == ALU_DIV) ? opa_reg : acc_reg;
                add_sub = 1'b1;
            end
            default:
            begin
                add_sub = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        op_next    = op_reg;
        opa_next   = opa_reg;
        opb_next   = opb_reg;
        acc_next   = acc_reg;
        res_next   = res_reg;
        cnt_next   = cnt_reg;
        neg_next   = neg_reg;
        zero_next  = zero_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (req.start)
                begin
                    op_next    = req.op;
                    opa_next   = x;
                    opb_next   = y;
                    acc_next   = '0;
                    neg_next   = (req.op == ALU_DIV) ? (x[W-1] ^ y[W-1]) : x[W-1];
                    zero_next  = 1'b0;
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                state_next = S_DONE;
                case (op_reg)
                    ALU_ADD, ALU_SUB: res_next = sum[W-1:0];
                    ALU_AND:          res_next = opa_reg & opb_reg;
                    ALU_OR:           res_next = opa_reg | opb_reg;
                    ALU_XOR:          res_next = opa_reg ^ opb_reg;
                    ALU_MUL:
                    begin
                        cnt_next   = CW'(W - 1);
                        state_next = S_ITER;
                    end
                    ALU_DIV, ALU_MOD:
                    begin
                        if (opb_reg == '0)
                        begin
                            zero_next = 1'b1;
                            res_next  = '0;
                        end
                        else
                        begin
                            state_next = S_MAGX;
                        end
                    end
                    default: res_next = '0;
                endcase
            end
            S_MAGX:
            begin
                if (opa_reg[W-1])
                begin
                    opa_next = sum[W-1:0];
                end
                state_next = S_MAGY;
            end
            S_MAGY:
            begin
                if (opb_reg[W-1])
                begin
                    opb_next = sum[W-1:0];
                end
                cnt_next   = CW'(W - 1);
                state_next = S_ITER;
            end
            S_ITER:
            begin
                if (op_reg == ALU_MUL)
                begin
                    if (opb_reg[0])
                    begin
                        acc_next = sum[W-1:0];
                    end
                    opa_next = {opa_reg[W-2:0], 1'b0};
                    opb_next = {1'b0, opb_reg[W-1:1]};
                end
                else if (!sum[W])
                begin
                    acc_next = sum[W-1:0];
                    opa_next = {opa_reg[W-2:0], 1'b1};
                end
                else
                begin
                    acc_next = div_sh;
                    opa_next = {opa_reg[W-2:0], 1'b0};
                end
                if (cnt_reg == '0)
                begin
                    if (op_reg == ALU_MUL)
                    begin
                        res_next   = acc_next;
                        state_next = S_DONE;
                    end
                    else
                    begin
                        state_next = S_FIX;
                    end
                end
                else
                begin
                    cnt_next = cnt_reg - CW'(1);
                end
            end
            S_FIX:
            begin
                if (neg_reg)
                begin
                    res_next = sum[W-1:0];
                end
                else
                begin
                    res_next = (op_reg == ALU_DIV) ? opa_reg : acc_reg;
                end
                state_next = S_DONE;
            end
            S_DONE:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            op_reg    <= ALU_ADD;
            opa_reg   <= '0;
            opb_reg   <= '0;
            acc_reg   <= '0;
            res_reg   <= '0;
            cnt_reg   <= '0;
            neg_reg   <= 1'b0;
            zero_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            op_reg    <= op_next;
            opa_reg   <= opa_next;
            opb_reg   <= opb_next;
            acc_reg   <= acc_next;
            res_reg   <= res_next;
            cnt_reg   <= cnt_next;
            neg_reg   <= neg_next;
            zero_reg  <= zero_next;
        end
    end

    assign result       = res_reg;
    assign rsp.done     = (state_reg == S_DONE);
    assign rsp.div_zero = zero_reg;

endmodule

/* sv/register_alu_instruction_executor.sv */
// ----------------------------------------------------------------------------
// register_alu_instruction_executor: decoded instruction executor
// Runs one instruction per transaction on a register file through a small
// sequencer and a shared iterative arithmetic unit.
//
//  channel | dir | payload (lowest bit first)
//  --------+-----+---------------------------------------------------------
//  s_      | in  | tdata: opcode, dest_index, src_a_index, src_b_index,
//          |     |        three_operand, immediate, zero pad
//  m_      | out | tdata: value; tuser: is_error
//
// Load and move write the register file in the dispatch state; exchange
// writes its second register in the exchange state; output and ALU ops go on.
// Multiply: one bit per cycle in the shared adder.
// Divide/modulo: one quotient bit per cycle; a zero divisor skips the
// iteration and gives an error result.
// Reset: asynchronous, register file reads as zero straight after reset.
// s_tready is low while a transaction is in flight; a held result in the
// output register does not stop the next transaction until it too has one.
// ----------------------------------------------------------------------------
module register_alu_instruction_executor #(
    parameter int NUM_REGS   = rae_pkg::DEF_NUM_REGS,
    parameter int DATA_WIDTH = rae_pkg::DEF_DATA_WIDTH
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // opcode[3:0], dest_index[8:4], src_a_index[13:9], src_b_index[18:14],
    // three_operand[19], immediate[51:20], pad[55:52]
    input  logic [rae_pkg::S_TDATA_W-1:0]   s_tdata,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // value[31:0]
    output logic [rae_pkg::M_TDATA_W-1:0]   m_tdata,
    // is_error[0]
    output logic                            m_tuser
);
    import rae_pkg::*;

    localparam int EXTW = (DATA_WIDTH > VAL_W) ? DATA_WIDTH : VAL_W;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DISPATCH,
        ST_XCHG,
        ST_WAIT,
        ST_OUT
    } state_t;

    state_t           state_reg, state_next;
    opcode_t          opc_reg, opc_next;
    logic [IDX_W-1:0] dest_reg, dest_next;
    logic [IDX_W-1:0] srca_reg, srca_next;
    logic [IMM_W-1:0] imm_reg, imm_next;
    logic             m_tvalid_reg, m_tvalid_next;
    logic [VAL_W-1:0] out_val_reg, out_val_next;
    logic             out_err_reg, out_err_next;

    opcode_t          in_opc;
    logic [IDX_W-1:0] in_dest;
    logic [IDX_W-1:0] in_srca;
    logic [IDX_W-1:0] in_srcb;
    logic             in_three;
    logic [IMM_W-1:0] in_imm;
    logic             in_alu;
    logic             accept;

    rf_rd_req_t            rf_rd;
    rf_wr_req_t            rf_wr;
    logic [DATA_WIDTH-1:0] rf_wdata;
    logic [DATA_WIDTH-1:0] rd0;
    logic [DATA_WIDTH-1:0] rd1;

    alu_req_t              alu_req;
    alu_rsp_t              alu_rsp;
    logic [DATA_WIDTH-1:0] alu_result;

    logic [EXTW-1:0]       imm_ext;
    logic [EXTW-1:0]       rd0_ext;

    assign in_opc   = opcode_t'(s_tdata[3:0]);
    assign in_dest  = s_tdata[8:4];
    assign in_srca  = s_tdata[13:9];
    assign in_srcb  = s_tdata[18:14];
    assign in_three = s_tdata[19];
    assign in_imm   = s_tdata[51:20];
    assign in_alu   = in_opc inside {[OP_ADD:OP_XOR]};

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;

    assign rf_rd.en   = accept;
    assign rf_rd.idx0 = (in_alu && in_three) ? in_srca : in_dest;
    assign rf_rd.idx1 = (in_alu && in_three) ? in_srcb : in_srca;

    assign imm_ext = EXTW'(signed'(imm_reg));
    assign rd0_ext = EXTW'(signed'(rd0));

    rae_regfile #(
        .NUM_REGS   (NUM_REGS),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_regfile (
        .clk      (clk),
        .rst_n    (rst_n),
        .rd       (rf_rd),
        .rd_data0 (rd0),
        .rd_data1 (rd1),
        .wr       (rf_wr),
        .wr_data  (rf_wdata)
    );

    assign alu_req.start = (state_reg == ST_DISPATCH) && (opc_reg inside {[OP_ADD:OP_XOR]});
    assign alu_req.op    = alu_op_of(opc_reg);

    rae_alu #(
        .DATA_WIDTH (DATA_WIDTH)
    ) u_alu (
        .clk    (clk),
        .rst_n  (rst_n),
        .req    (alu_req),
        .x      (rd0),
        .y      (rd1),
        .result (alu_result),
        .rsp    (alu_rsp)
    );

    always_comb
    begin
        state_next    = state_reg;
        opc_next      = opc_reg;
        dest_next     = dest_reg;
        srca_next     = srca_reg;
        imm_next      = imm_reg;
        out_val_next  = out_val_reg;
        out_err_next  = out_err_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        rf_wr.en      = 1'b0;
        rf_wr.idx     = dest_reg;
        rf_wdata      = rd1;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    opc_next   = in_opc;
                    dest_next  = in_dest;
                    srca_next  = in_srca;
                    imm_next   = in_imm;
                    state_next = ST_DISPATCH;
                end
            end
            ST_DISPATCH:
            begin
                case (opc_reg)
                    OP_LOAD:
                    begin
                        rf_wr.en   = 1'b1;
                        rf_wdata   = imm_ext[DATA_WIDTH-1:0];
                        state_next = ST_IDLE;
                    end
                    OP_OUTPUT:
                    begin
                        state_next = ST_OUT;
                    end
                    OP_MOVE:
                    begin
                        rf_wr.en   = 1'b1;
                        state_next = ST_IDLE;
                    end
                    OP_EXCH:
                    begin
                        rf_wr.en   = 1'b1;
                        state_next = ST_XCHG;
                    end
                    OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_MOD, OP_AND, OP_OR, OP_XOR:
                    begin
                        state_next = ST_WAIT;
                    end
                    default:
                    begin
                        state_next = ST_IDLE;
                    end
                endcase
            end
            ST_XCHG:
            begin
                rf_wr.en   = 1'b1;
                rf_wr.idx  = srca_reg;
                rf_wdata   = rd0;
                state_next = ST_IDLE;
            end
            ST_WAIT:
            begin
                if (alu_rsp.done)
                begin
                    if (alu_rsp.div_zero)
                    begin
                        state_next = ST_OUT;
                    end
                    else
                    begin
                        rf_wr.en   = 1'b1;
                        rf_wdata   = alu_result;
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_OUT:
            begin
                if (!m_tvalid_reg || m_tready)
                begin
                    out_err_next  = (opc_reg != OP_OUTPUT);
                    out_val_next  = (opc_reg == OP_OUTPUT) ? rd0_ext[VAL_W-1:0] : '0;
                    m_tvalid_next = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            opc_reg      <= OP_LOAD;
            dest_reg     <= '0;
            srca_reg     <= '0;
            imm_reg      <= '0;
            m_tvalid_reg <= 1'b0;
            out_val_reg  <= '0;
            out_err_reg  <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            opc_reg      <= opc_next;
            dest_reg     <= dest_next;
            srca_reg     <= srca_next;
            imm_reg      <= imm_next;
            m_tvalid_reg <= m_tvalid_next;
            out_val_reg  <= out_val_next;
            out_err_reg  <= out_err_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = out_val_reg;
    assign m_tuser  = out_err_reg;

    // divide-by-zero only ever comes back for a divide or modulo
    a_div_zero_op: assert property (@(posedge clk) disable iff (!rst_n)
        alu_rsp.done && alu_rsp.div_zero |-> (opc_reg == OP_DIV || opc_reg == OP_MOD))
        else $error("divide-by-zero flag on non-divide instruction");

    a_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
        alu_rsp.done |-> state_reg == ST_WAIT)
        else $error("ALU completion outside wait state");

    a_accept_dispatch: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> state_reg == ST_DISPATCH && !s_tready)
        else $error("accepted transaction not dispatched");

    a_out_from_seq: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(state_reg == ST_OUT))
        else $error("result raised outside output state");

    a_error_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser |-> m_tdata == '0)
        else $error("error result carries non-zero value");

endmodule
